// ----- hdl/tmrc_pkg.sv -----
// Shared types, sizes and codes of the tile map collision block.
`default_nettype none
package tmrc_pkg;

  // Grid limits and derived widths
  localparam int MaxCols  = 64;
  localparam int MaxRows  = 64;
  localparam int Depth    = MaxCols * MaxRows;
  localparam int ColW     = $clog2(MaxCols);
  localparam int RowW     = $clog2(MaxRows);
  localparam int AddrW    = $clog2(Depth);

  // Field widths fixed by the register map
  localparam int CoordW   = 16;
  localparam int SizeW    = 11;
  localparam int CountW   = 7;
  localparam int RectW    = 15;
  localparam int TileW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Divider: numerator covers the largest non-negative pixel distance
  localparam int NumW     = 17;
  localparam int DivCntW  = $clog2(NumW);

  // Commands
  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOffsetX    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOffsetY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCellWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCellHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCellsAcr   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCellsDown  = 3'd5;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [CoordW-1:0] tile_col;
    logic signed [CoordW-1:0] tile_row;
    logic signed [TileW-1:0]  write_value;
    logic signed [CoordW-1:0] rect_x;
    logic signed [CoordW-1:0] rect_y;
    logic [RectW-1:0]         rect_width;
    logic [RectW-1:0]         rect_height;
    logic signed [TileW-1:0]  match_value;
  } in_word_t;

  typedef struct packed {
    logic                    hit;
    logic signed [TileW-1:0] read_value;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [NumW-1:0]  num;
    logic [SizeW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/tmrc_in_if.sv -----
// Input channel: command words into the block.
`default_nettype none
interface tmrc_in_if;
  import tmrc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/tmrc_out_if.sv -----
// Output channel: result words out of the block.
`default_nettype none
interface tmrc_out_if;
  import tmrc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/tile_map_rect_collision_core.sv -----
// Top level: tile grid with write, read and rectangle collision query.
// One word in flight at a time; a result register lets the next word in while a result waits.
// Query: two division rounds (x and y in parallel on iterative dividers), then a scan of the
// covered cells that stops at the first match; a query that misses the grid bounds skips both.
// Async active-low reset clears control regs and loads the config regs with their defaults;
// tile memory is not cleared and must be written before it is read.
`default_nettype none
module tile_map_rect_collision_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tmrc_in_if.sink                       in_i,
  tmrc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [tmrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tmrc_pkg::CfgDataW-1:0] cfg_data_i
);
  import tmrc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADDR  = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_RDW   = 4'd3;
  localparam logic [3:0] S_BND   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_DIVB  = 4'd6;
  localparam logic [3:0] S_DIVE  = 4'd7;
  localparam logic [3:0] S_SCANI = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_DRAIN = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  // config registers
  logic signed [CoordW-1:0] ox_q, oy_q;
  logic [SizeW-1:0]         cw_q, ch_q;
  logic [CountW-1:0]        ca_q, cd_q;

  logic [3:0]   state_q, state_d;
  in_word_t     item_q, item_d;
  logic         out_valid_q, out_valid_d;
  out_word_t    out_q, out_d;
  logic         pend_q, pend_d;
  logic         hit_q, hit_d;
  logic [TileW-1:0] rv_q, rv_d;
  logic         in_grid_q, in_grid_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [SizeW+CountW-1:0] wide_q, wide_d, tall_q, tall_d;
  logic         xneg_q, xneg_d, yneg_q, yneg_d;
  logic [ColW-1:0] xb_q, xb_d, xe_q, xe_d, x_q, x_d;
  logic [RowW-1:0] yb_q, yb_d, ye_q, ye_d, y_q, y_d;
  logic [AddrW-1:0] row_q, row_d;

  logic [CountW-1:0] cols_eff, rows_eff;
  logic [SizeW-1:0]  cw_eff, ch_eff;
  logic signed [19:0] rx_s, ry_s, rw_s, rh_s, ox_s, oy_s, wide_s, tall_s;
  logic signed [19:0] nbx, nby, nex, ney;
  logic              miss;
  div_req_t          dreq_x, dreq_y;
  div_rsp_t          drsp_x, drsp_y;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_addr;
  logic [TileW-1:0]  mem_rdata;
  logic              in_acc;

  // effective grid geometry
  always_comb begin
    cols_eff = (ca_q == '0) ? CountW'(1) : (ca_q > CountW'(MaxCols)) ? CountW'(MaxCols) : ca_q;
    rows_eff = (cd_q == '0) ? CountW'(1) : (cd_q > CountW'(MaxRows)) ? CountW'(MaxRows) : cd_q;
    cw_eff   = (cw_q == '0) ? SizeW'(1) : cw_q;
    ch_eff   = (ch_q == '0) ? SizeW'(1) : ch_q;
  end

  // pixel arithmetic for the query, all at 20 bits signed
  always_comb begin
    rx_s   = {{4{item_q.rect_x[CoordW-1]}}, item_q.rect_x};
    ry_s   = {{4{item_q.rect_y[CoordW-1]}}, item_q.rect_y};
    rw_s   = {5'b0, item_q.rect_width};
    rh_s   = {5'b0, item_q.rect_height};
    ox_s   = {{4{ox_q[CoordW-1]}}, ox_q};
    oy_s   = {{4{oy_q[CoordW-1]}}, oy_q};
    wide_s = {2'b0, wide_q};
    tall_s = {2'b0, tall_q};
    nbx    = rx_s - ox_s;
    nby    = ry_s - oy_s;
    nex    = rx_s + rw_s - 20'sd1 - ox_s;
    ney    = ry_s + rh_s - 20'sd1 - oy_s;
    miss   = (rx_s + rw_s < ox_s) || (ry_s + rh_s < oy_s) ||
             (rx_s >= ox_s + wide_s) || (ry_s >= oy_s + tall_s);
  end

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    rv_d        = rv_q;
    in_grid_d   = in_grid_q;
    addr_d      = addr_q;
    wide_d      = wide_q;
    tall_d      = tall_q;
    xneg_d      = xneg_q;
    yneg_d      = yneg_q;
    xb_d = xb_q; xe_d = xe_q; x_d = x_q;
    yb_d = yb_q; ye_d = ye_q; y_d = y_q;
    row_d       = row_q;
    dreq_x      = '{start: 1'b0, num: '0, den: cw_eff};
    dreq_y      = '{start: 1'b0, num: '0, den: ch_eff};
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = addr_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_d = in_i.data;
          hit_d  = 1'b0;
          rv_d   = '0;
          pend_d = 1'b0;
          case (in_i.data.command)
            CmdWrite, CmdRead: state_d = S_ADDR;
            CmdQuery:          state_d = S_BND;
            default:           state_d = S_FIN;
          endcase
        end
      end
      // grid check and linear address of one tile
      S_ADDR: begin
        in_grid_d = !item_q.tile_col[CoordW-1] && !item_q.tile_row[CoordW-1] &&
                    (item_q.tile_col < CoordW'(cols_eff)) &&
                    (item_q.tile_row < CoordW'(rows_eff));
        addr_d    = AddrW'(item_q.tile_row[RowW-1:0]) * AddrW'(cols_eff) +
                    AddrW'(item_q.tile_col[ColW-1:0]);
        state_d   = S_ACC;
      end
      S_ACC: begin
        if (item_q.command == CmdWrite) begin
          mem_we  = in_grid_q;
          state_d = S_FIN;
        end else begin
          mem_re  = in_grid_q;
          state_d = S_RDW;
        end
      end
      S_RDW: begin
        rv_d    = in_grid_q ? mem_rdata : {TileW{1'b1}};
        state_d = S_FIN;
      end
      // grid extent in pixels
      S_BND: begin
        wide_d  = cw_eff * cols_eff;
        tall_d  = ch_eff * rows_eff;
        state_d = S_CHK;
      end
      // bounds test, then divide the start edges
      S_CHK: begin
        if (miss) begin
          state_d = S_FIN;
        end else begin
          xneg_d       = nex[19] && (cw_eff == SizeW'(1));
          yneg_d       = ney[19] && (ch_eff == SizeW'(1));
          dreq_x.start = 1'b1;
          dreq_x.num   = nbx[19] ? '0 : nbx[NumW-1:0];
          dreq_y.start = 1'b1;
          dreq_y.num   = nby[19] ? '0 : nby[NumW-1:0];
          state_d      = S_DIVB;
        end
      end
      // start cells known, divide the end edges
      S_DIVB: begin
        if (drsp_x.done) begin
          xb_d         = drsp_x.quo[ColW-1:0];
          yb_d         = drsp_y.quo[RowW-1:0];
          dreq_x.start = 1'b1;
          dreq_x.num   = nex[19] ? '0 : nex[NumW-1:0];
          dreq_y.start = 1'b1;
          dreq_y.num   = ney[19] ? '0 : ney[NumW-1:0];
          state_d      = S_DIVE;
        end
      end
      // clamp end cells to the grid
      S_DIVE: begin
        if (drsp_x.done) begin
          xe_d    = (drsp_x.quo >= NumW'(cols_eff)) ? ColW'(cols_eff - 1'b1)
                                                    : drsp_x.quo[ColW-1:0];
          ye_d    = (drsp_y.quo >= NumW'(rows_eff)) ? RowW'(rows_eff - 1'b1)
                                                    : drsp_y.quo[RowW-1:0];
          state_d = S_SCANI;
        end
      end
      S_SCANI: begin
        if (xneg_q || yneg_q || (xe_q < xb_q) || (ye_q < yb_q)) begin
          state_d = S_FIN;
        end else begin
          x_d     = xb_q;
          y_d     = yb_q;
          row_d   = AddrW'(yb_q) * AddrW'(cols_eff);
          state_d = S_SCAN;
        end
      end
      // one cell read per cycle, compared from the registered read data
      S_SCAN: begin
        if (pend_q && (mem_rdata == item_q.match_value)) begin
          hit_d   = 1'b1;
          pend_d  = 1'b0;
          state_d = S_FIN;
        end else begin
          mem_re   = 1'b1;
          mem_addr = row_q + AddrW'(x_q);
          pend_d   = 1'b1;
          if (x_q == xe_q) begin
            x_d   = xb_q;
            y_d   = y_q + 1'b1;
            row_d = row_q + AddrW'(cols_eff);
            if (y_q == ye_q) begin
              state_d = S_DRAIN;
            end
          end else begin
            x_d = x_q + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        pend_d  = 1'b0;
        hit_d   = (mem_rdata == item_q.match_value);
        state_d = S_FIN;
      end
      // hand the result to the output register
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = '{hit: hit_q, read_value: rv_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      ox_q        <= '0;
      oy_q        <= '0;
      cw_q        <= SizeW'(16);
      ch_q        <= SizeW'(16);
      ca_q        <= CountW'(64);
      cd_q        <= CountW'(64);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgOffsetX:    ox_q <= cfg_data_i;
          CfgOffsetY:    oy_q <= cfg_data_i;
          CfgCellWidth:  cw_q <= cfg_data_i[SizeW-1:0];
          CfgCellHeight: ch_q <= cfg_data_i[SizeW-1:0];
          CfgCellsAcr:   ca_q <= cfg_data_i[CountW-1:0];
          CfgCellsDown:  cd_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    out_q     <= out_d;
    hit_q     <= hit_d;
    rv_q      <= rv_d;
    in_grid_q <= in_grid_d;
    addr_q    <= addr_d;
    wide_q    <= wide_d;
    tall_q    <= tall_d;
    xneg_q    <= xneg_d;
    yneg_q    <= yneg_d;
    xb_q      <= xb_d;
    xe_q      <= xe_d;
    x_q       <= x_d;
    yb_q      <= yb_d;
    ye_q      <= ye_d;
    y_q       <= y_d;
    row_q     <= row_d;
  end

  tmrc_div u_div_x (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq_x), .rsp_o(drsp_x));
  tmrc_div u_div_y (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq_y), .rsp_o(drsp_y));

  tmrc_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (item_q.write_value),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

// ----- hdl/tmrc_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module tmrc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tmrc_pkg::div_req_t req_i,
  output tmrc_pkg::div_rsp_t rsp_o
);
  import tmrc_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [NumW-1:0]     num_q, num_d;
  logic [SizeW-1:0]    rem_q, rem_d;
  logic [SizeW-1:0]    den_q, den_d;
  logic [SizeW:0]      rem_sh;
  logic [SizeW:0]      diff;
  logic                ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_q, num_q[NumW-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = rem_sh >= {1'b0, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(NumW - 1);
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? diff[SizeW-1:0] : rem_sh[SizeW-1:0];
      num_d = {num_q[NumW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

endmodule
`default_nettype wire

// ----- hdl/tmrc_store.sv -----
// Tile memory: single port, registered read data.
`default_nettype none
module tmrc_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [tmrc_pkg::AddrW-1:0] addr_i,
  input  logic [tmrc_pkg::TileW-1:0] wdata_i,
  output logic [tmrc_pkg::TileW-1:0] rdata_o
);
  import tmrc_pkg::*;

  logic [TileW-1:0] mem [Depth];
  logic [TileW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/tmrc_checker.sv -----
// Port-level checks of the collision block, bound to the top level.
`default_nettype none
module tmrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [15:0] out_read_value
);

  // one word in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word was in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit) && $stable(out_read_value)))
    else $error("stalled result changed");

  // a result never carries both a hit and a non-zero read value
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_hit && (out_read_value != 16'd0)))
    else $error("hit and read value both set");

  // the output is idle as reset is released
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind tile_map_rect_collision_core tmrc_checker u_tmrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .out_hit        (out_o.data.hit),
  .out_read_value (out_o.data.read_value)
);
`default_nettype wire
